// ===== src/fvcw_pkg.sv =====
// shared constants, types and the color wheel table for the flow color coder
package fvcw_pkg;

  localparam int FLOW_W              = 16;
  localparam int COLOR_W             = 8;
  localparam int MOTION_W            = 8;
  localparam int FLOW_FRAC_BITS_DEF  = 8;
  localparam logic [MOTION_W-1:0] MAX_MOTION_RST = 8'd10;

  // wheel segments: red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta, magenta-red
  localparam int SEG_RY     = 15;
  localparam int SEG_YG     = 6;
  localparam int SEG_GC     = 4;
  localparam int SEG_CB     = 11;
  localparam int SEG_BM     = 13;
  localparam int SEG_MR     = 6;
  localparam int WHEEL_SIZE = SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM + SEG_MR;
  localparam int WHEEL_IDX_W = $clog2(WHEEL_SIZE);

  // angles in q16 radians
  localparam int PI_Q16            = 205887;
  localparam int TWO_PI_Q16        = 411775;
  localparam int WHEEL_PER_RAD_Q16 = 563240;
  localparam int THETA_W           = 19;
  localparam int SCALE_W           = 20;
  localparam int POS_W             = THETA_W + SCALE_W;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 28;
  localparam int ANGLE_W      = 21;

  localparam int ATAN_Q16 [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // radius path
  localparam int SUMSQ_W    = 32;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 36;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_IN_STEPS = SUMSQ_W / 2;
  localparam int RAD_W      = 17;
  localparam int DIV_STEPS  = RAD_W;

  localparam int BLEND_W = 24;
  localparam int PROD_W  = BLEND_W + RAD_W;

  typedef logic [3*COLOR_W-1:0] rgb_t;
  typedef rgb_t wheel_lut_t [WHEEL_SIZE];

  function automatic wheel_lut_t wheel_build();
    wheel_lut_t lut;
    int r;
    int g;
    int b;
    int j;
    for (int k = 0; k < WHEEL_SIZE; k++) begin
      if (k < SEG_RY) begin
        r = 255; g = 255 * k / SEG_RY; b = 0;
      end else if (k < SEG_RY + SEG_YG) begin
        j = k - SEG_RY;
        r = 255 - 255 * j / SEG_YG; g = 255; b = 0;
      end else if (k < SEG_RY + SEG_YG + SEG_GC) begin
        j = k - SEG_RY - SEG_YG;
        r = 0; g = 255; b = 255 * j / SEG_GC;
      end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
        j = k - SEG_RY - SEG_YG - SEG_GC;
        r = 0; g = 255 - 255 * j / SEG_CB; b = 255;
      end else if (k < WHEEL_SIZE - SEG_MR) begin
        j = k - SEG_RY - SEG_YG - SEG_GC - SEG_CB;
        r = 255 * j / SEG_BM; g = 0; b = 255;
      end else begin
        j = k - (WHEEL_SIZE - SEG_MR);
        r = 255; g = 0; b = 255 - 255 * j / SEG_MR;
      end
      lut[k] = {COLOR_W'(r), COLOR_W'(g), COLOR_W'(b)};
    end
    return lut;
  endfunction

  localparam wheel_lut_t WHEEL_LUT = wheel_build();

endpackage

// ===== src/flow_vector_color_wheel.sv =====
// flow vector to color wheel pixel coder, fully pipelined
//
// channel   direction  signals                                   transfer
// command   in         start_i, busy_o, flow_x_i, flow_y_i,      start_i high, busy_o low
//                      flow_valid_i
// config    in         cfg_we_i, cfg_data_i (max_motion)         cfg_we_i high
// result    out        done_o, red_o, green_o, blue_o            done_o high, one cycle
//
// one vector enters every cycle; busy_o stays low
// the latency is set by the radius path: squares, a 32-step
//   square root (one result bit a stage) and a 17-step divide by the motion limit
// the angle path (16 cordic stages, wheel lookup, blend) is shorter and is
//   brought in line with the radius path by a delay line
// reset clears the valid bits of every stage and loads max_motion with 10
// the receiver cannot stall, so nothing in the pipeline ever holds
module flow_vector_color_wheel #(
  parameter int FLOW_FRAC_BITS = fvcw_pkg::FLOW_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [fvcw_pkg::FLOW_W-1:0]   flow_x_i,
  input  logic signed [fvcw_pkg::FLOW_W-1:0]   flow_y_i,
  input  logic                                 flow_valid_i,
  input  logic                                 cfg_we_i,
  input  logic        [fvcw_pkg::MOTION_W-1:0] cfg_data_i,
  output logic                                 done_o,
  output logic        [fvcw_pkg::COLOR_W-1:0]  red_o,
  output logic        [fvcw_pkg::COLOR_W-1:0]  green_o,
  output logic        [fvcw_pkg::COLOR_W-1:0]  blue_o
);
  import fvcw_pkg::*;

  localparam int DW        = MOTION_W + FLOW_FRAC_BITS;
  localparam int DDW       = 2 * DW;
  localparam int CMPW      = (DDW > SUMSQ_W) ? DDW : SUMSQ_W;
  localparam int LAT_A     = 2 + SQRT_STEPS + DIV_STEPS;
  localparam int LAT_B     = 5 + CORDIC_STEPS;
  localparam int DLY       = LAT_A - LAT_B;
  localparam int LAT_TOTAL = LAT_A + 3;

  // the pipeline never holds
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // motion limit register and derived divisor
  // ---------------------------------------------------------------------------
  logic [MOTION_W-1:0] max_motion_q;
  logic [MOTION_W-1:0] motion_eff;
  logic [DW-1:0]       div_d;
  logic [DW-1:0]       d_q;
  logic [DDW-1:0]      dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_motion_q <= MAX_MOTION_RST;
    end else if (cfg_we_i) begin
      max_motion_q <= cfg_data_i;
    end
  end

  // zero acts as one
  assign motion_eff = (max_motion_q == '0) ? MOTION_W'(1) : max_motion_q;
  assign div_d      = DW'(motion_eff) << FLOW_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    d_q  <= div_d;
    dd_q <= DDW'(div_d) * DDW'(div_d);
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                     in_vld_q;
  logic                     in_fv_q;
  logic signed [FLOW_W-1:0] in_x_q;
  logic signed [FLOW_W-1:0] in_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_fv_q <= flow_valid_i;
    in_x_q  <= flow_x_i;
    in_y_q  <= flow_y_i;
  end

  // ---------------------------------------------------------------------------
  // radius path: squares, sum and inside test
  // ---------------------------------------------------------------------------
  logic signed [2*FLOW_W-1:0] px;
  logic signed [2*FLOW_W-1:0] py;
  logic                       a1_vld_q;
  logic                       a1_fv_q;
  logic [SUMSQ_W-2:0]         a1_sqx_q;
  logic [SUMSQ_W-2:0]         a1_sqy_q;
  logic                       a2_vld_q;
  logic                       a2_fv_q;
  logic                       a2_in_q;
  logic [SUMSQ_W-1:0]         a2_sum_q;
  logic [SUMSQ_W-1:0]         sumsq;

  assign px    = in_x_q * in_x_q;
  assign py    = in_y_q * in_y_q;
  assign sumsq = {1'b0, a1_sqx_q} + {1'b0, a1_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_vld_q <= 1'b0;
      a2_vld_q <= 1'b0;
    end else begin
      a1_vld_q <= in_vld_q;
      a2_vld_q <= a1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_fv_q  <= in_fv_q;
    a1_sqx_q <= px[SUMSQ_W-2:0];
    a1_sqy_q <= py[SUMSQ_W-2:0];
    a2_fv_q  <= a1_fv_q;
    a2_sum_q <= sumsq;
    a2_in_q  <= CMPW'(sumsq) <= CMPW'(dd_q);
  end

  // ---------------------------------------------------------------------------
  // square root of sumsq * 2^32, one root bit per stage
  // ---------------------------------------------------------------------------
  logic                 sq_vld_q  [SQRT_STEPS];
  logic                 sq_fv_q   [SQRT_STEPS];
  logic                 sq_in_q   [SQRT_STEPS];
  logic [SUMSQ_W-1:0]   sq_n_q    [SQRT_STEPS];
  logic [ROOT_W-1:0]    sq_root_q [SQRT_STEPS];
  logic [REM_W-1:0]     sq_rem_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic               vld_p;
    logic               fv_p;
    logic               in_p;
    logic [SUMSQ_W-1:0] n_p;
    logic [ROOT_W-1:0]  root_p;
    logic [REM_W-1:0]   rem_p;
    logic [1:0]         pair;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_p  = a2_vld_q;
      assign fv_p   = a2_fv_q;
      assign in_p   = a2_in_q;
      assign n_p    = a2_sum_q;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_next
      assign vld_p  = sq_vld_q[k-1];
      assign fv_p   = sq_fv_q[k-1];
      assign in_p   = sq_in_q[k-1];
      assign n_p    = sq_n_q[k-1];
      assign root_p = sq_root_q[k-1];
      assign rem_p  = sq_rem_q[k-1];
    end

    // the low half of the radicand is all zeros
    if (k < SQRT_IN_STEPS) begin : g_pair
      assign pair = n_p[SUMSQ_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_p[REM_W-3:0], pair};
    assign trial  = {2'b00, root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_fv_q[k]   <= fv_p;
      sq_in_q[k]   <= in_p;
      sq_n_q[k]    <= n_p;
      sq_root_q[k] <= {root_p[ROOT_W-2:0], ge};
      sq_rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
    end
  end

  // ---------------------------------------------------------------------------
  // radius = root / d, one quotient bit per stage; only meaningful inside
  // ---------------------------------------------------------------------------
  logic             dv_vld_q [DIV_STEPS];
  logic             dv_fv_q  [DIV_STEPS];
  logic             dv_in_q  [DIV_STEPS];
  logic [RAD_W-1:0] dv_s_q   [DIV_STEPS];
  logic [DW-1:0]    dv_r_q   [DIV_STEPS];
  logic [RAD_W-1:0] dv_q_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic             vld_p;
    logic             fv_p;
    logic             in_p;
    logic [RAD_W-1:0] s_p;
    logic [DW-1:0]    r_p;
    logic [RAD_W-1:0] q_p;
    logic [DW:0]      r_sh;
    logic [DW:0]      d_ext;
    logic             ge;
    logic [DW:0]      r_sub;

    if (k == 0) begin : g_first
      assign vld_p = sq_vld_q[SQRT_STEPS-1];
      assign fv_p  = sq_fv_q[SQRT_STEPS-1];
      assign in_p  = sq_in_q[SQRT_STEPS-1];
      assign s_p   = sq_root_q[SQRT_STEPS-1][RAD_W-1:0];
      assign r_p   = DW'(sq_root_q[SQRT_STEPS-1] >> RAD_W);
      assign q_p   = '0;
    end else begin : g_next
      assign vld_p = dv_vld_q[k-1];
      assign fv_p  = dv_fv_q[k-1];
      assign in_p  = dv_in_q[k-1];
      assign s_p   = dv_s_q[k-1];
      assign r_p   = dv_r_q[k-1];
      assign q_p   = dv_q_q[k-1];
    end

    assign r_sh  = {r_p, s_p[RAD_W-1-k]};
    assign d_ext = {1'b0, d_q};
    assign ge    = r_sh >= d_ext;
    assign r_sub = r_sh - d_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_fv_q[k] <= fv_p;
      dv_in_q[k] <= in_p;
      dv_s_q[k]  <= s_p;
      dv_r_q[k]  <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
      dv_q_q[k]  <= {q_p[RAD_W-2:0], ge};
    end
  end

  // ---------------------------------------------------------------------------
  // angle path: half-turn pre-rotation and scale by 256
  // ---------------------------------------------------------------------------
  logic signed [FLOW_W:0]     xe;
  logic signed [FLOW_W:0]     ye;
  logic signed [FLOW_W:0]     xa;
  logic signed [FLOW_W:0]     ya;
  logic signed [CORDIC_W-1:0] b1_x_q;
  logic signed [CORDIC_W-1:0] b1_y_q;
  logic                       b1_base_q;
  logic                       b1_zero_q;

  assign xe = {in_x_q[FLOW_W-1], in_x_q};
  assign ye = {in_y_q[FLOW_W-1], in_y_q};
  assign xa = in_x_q[FLOW_W-1] ? -xe : xe;
  assign ya = in_x_q[FLOW_W-1] ? -ye : ye;

  always_ff @(posedge clk_i) begin
    b1_x_q    <= CORDIC_W'(xa) <<< 8;
    b1_y_q    <= CORDIC_W'(ya) <<< 8;
    b1_base_q <= in_x_q[FLOW_W-1];
    b1_zero_q <= (in_x_q == '0) && (in_y_q == '0);
  end

  // ---------------------------------------------------------------------------
  // cordic vectoring, one rotation per stage
  // ---------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] cr_x_q    [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cr_y_q    [CORDIC_STEPS];
  logic signed [ANGLE_W-1:0]  cr_z_q    [CORDIC_STEPS];
  logic                       cr_base_q [CORDIC_STEPS];
  logic                       cr_zero_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] x_p;
    logic signed [CORDIC_W-1:0] y_p;
    logic signed [ANGLE_W-1:0]  z_p;
    logic                       base_p;
    logic                       zero_p;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ANGLE_W-1:0]  at;

    if (i == 0) begin : g_first
      assign x_p    = b1_x_q;
      assign y_p    = b1_y_q;
      assign z_p    = '0;
      assign base_p = b1_base_q;
      assign zero_p = b1_zero_q;
    end else begin : g_next
      assign x_p    = cr_x_q[i-1];
      assign y_p    = cr_y_q[i-1];
      assign z_p    = cr_z_q[i-1];
      assign base_p = cr_base_q[i-1];
      assign zero_p = cr_zero_q[i-1];
    end

    assign xs = x_p >>> i;
    assign ys = y_p >>> i;
    assign at = ANGLE_W'(ATAN_Q16[i]);

    always_ff @(posedge clk_i) begin
      if (!y_p[CORDIC_W-1]) begin
        cr_x_q[i] <= x_p + ys;
        cr_y_q[i] <= y_p - xs;
        cr_z_q[i] <= z_p + at;
      end else begin
        cr_x_q[i] <= x_p - ys;
        cr_y_q[i] <= y_p + xs;
        cr_z_q[i] <= z_p - at;
      end
      cr_base_q[i] <= base_p;
      cr_zero_q[i] <= zero_p;
    end
  end

  // ---------------------------------------------------------------------------
  // fold angle into [0, 2pi), scale to wheel position, look up and blend
  // ---------------------------------------------------------------------------
  logic signed [ANGLE_W-1:0] theta_raw;
  logic signed [ANGLE_W-1:0] theta_fold;
  logic [THETA_W-1:0]        th_q;
  logic [POS_W-1:0]          pos_q;
  logic [POS_W-33:0]         k0_raw;
  logic [WHEEL_IDX_W-1:0]    k0;
  logic [WHEEL_IDX_W-1:0]    k1;
  logic [15:0]               lk_f_q;
  rgb_t                      lk_c0_q;
  rgb_t                      lk_c1_q;
  logic [16:0]               f_inv;
  rgb_t                      c0;
  rgb_t                      c1;
  logic [2:0][BLEND_W-1:0]   bl_v;
  logic [2:0][BLEND_W-1:0]   bl_v_q;

  assign theta_raw = cr_base_q[CORDIC_STEPS-1]
                   ? cr_z_q[CORDIC_STEPS-1] + ANGLE_W'(PI_Q16)
                   : cr_z_q[CORDIC_STEPS-1];

  always_comb begin
    theta_fold = theta_raw;
    if (theta_raw < 0) begin
      theta_fold = theta_raw + ANGLE_W'(TWO_PI_Q16);
    end else if (theta_raw >= ANGLE_W'(TWO_PI_Q16)) begin
      theta_fold = theta_raw - ANGLE_W'(TWO_PI_Q16);
    end
  end

  // integer wheel index capped at the last entry, upper neighbour wraps
  assign k0_raw = pos_q[POS_W-1:32];
  assign k0     = (k0_raw > (POS_W-32)'(WHEEL_SIZE - 1))
                ? WHEEL_IDX_W'(WHEEL_SIZE - 1) : k0_raw[WHEEL_IDX_W-1:0];
  assign k1     = (k0 == WHEEL_IDX_W'(WHEEL_SIZE - 1)) ? '0 : k0 + 1'b1;
  assign c0     = WHEEL_LUT[k0];
  assign c1     = WHEEL_LUT[k1];
  assign f_inv  = 17'h10000 - {1'b0, lk_f_q};

  for (genvar ch = 0; ch < 3; ch++) begin : g_blend
    logic [BLEND_W:0] sum;
    assign sum = (BLEND_W+1)'(lk_c0_q[3*COLOR_W-1-COLOR_W*ch -: COLOR_W]) * (BLEND_W+1)'(f_inv)
               + (BLEND_W+1)'(lk_c1_q[3*COLOR_W-1-COLOR_W*ch -: COLOR_W]) * (BLEND_W+1)'(lk_f_q);
    assign bl_v[ch] = sum[BLEND_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    th_q    <= cr_zero_q[CORDIC_STEPS-1] ? '0 : theta_fold[THETA_W-1:0];
    pos_q   <= POS_W'(th_q) * POS_W'(WHEEL_PER_RAD_Q16);
    lk_f_q  <= pos_q[31:16];
    lk_c0_q <= c0;
    lk_c1_q <= c1;
    bl_v_q  <= bl_v;
  end

  // line up the blended color with the radius
  logic [2:0][BLEND_W-1:0] dl_q [DLY];

  always_ff @(posedge clk_i) begin
    dl_q[0] <= bl_v_q;
    for (int i = 1; i < DLY; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // desaturate inside the circle, scale by 3/4 outside, black for an invalid vector
  // ---------------------------------------------------------------------------
  logic                    fn_vld_q;
  logic                    fn_fv_q;
  logic                    fn_in_q;
  logic [2:0][BLEND_W-1:0] fn_v_q;
  logic [2:0][PROD_W-1:0]  fn_prod_q;
  logic [2:0][PROD_W-1:0]  prod;
  logic [2:0][COLOR_W-1:0] color;
  logic                    done_q;
  logic [2:0][COLOR_W-1:0] color_q;

  for (genvar ch = 0; ch < 3; ch++) begin : g_out
    logic [BLEND_W-1:0] w;
    logic [PROD_W-1:0]  diff;
    logic [BLEND_W+1:0] three_v;

    // distance of the blended color from white
    assign w        = BLEND_W'(255 * 65536) - dl_q[DLY-1][ch];
    assign prod[ch] = PROD_W'(w) * PROD_W'(dv_q_q[DIV_STEPS-1]);
    assign diff     = (PROD_W'(255) << 32) - fn_prod_q[ch];
    assign three_v  = {1'b0, fn_v_q[ch], 1'b0} + (BLEND_W+2)'(fn_v_q[ch]);

    always_comb begin
      if (!fn_fv_q) begin
        color[ch] = '0;
      end else if (fn_in_q) begin
        color[ch] = diff[39:32];
      end else begin
        color[ch] = three_v[25:18];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      fn_vld_q <= dv_vld_q[DIV_STEPS-1];
      done_q   <= fn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_fv_q   <= dv_fv_q[DIV_STEPS-1];
    fn_in_q   <= dv_in_q[DIV_STEPS-1];
    fn_v_q    <= dl_q[DLY-1];
    fn_prod_q <= prod;
    color_q   <= color;
  end

  assign done_o  = done_q;
  assign red_o   = color_q[0];
  assign green_o = color_q[1];
  assign blue_o  = color_q[2];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT_TOTAL))
    else $error("result without a matching command transfer");

  a_root_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_vld_q[SQRT_STEPS-1] && sq_in_q[SQRT_STEPS-1])
      |-> (32'(sq_root_q[SQRT_STEPS-1][ROOT_W-1:16]) <= 32'(d_q)))
    else $error("square root exceeds motion limit for an inside vector");

  a_rad_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DIV_STEPS-1] && dv_in_q[DIV_STEPS-1])
      |-> (dv_q_q[DIV_STEPS-1] <= RAD_W'(65536)))
    else $error("radius above one for an inside vector");

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the flow vector colour wheel coder
`timescale 1ns / 100ps

module tb;
  import fvcw_pkg::*;

  localparam int FRAC       = FLOW_FRAC_BITS_DEF;
  localparam int DRAIN_CYC  = 150;     // well beyond the pipeline depth
  localparam int LIMIT_CYC  = 400000;  // generous run limit

  // expected pixel colors, matched in order against done_o strobes
  class pixel_scoreboard;
    logic [COLOR_W-1:0] exp_r[$];
    logic [COLOR_W-1:0] exp_g[$];
    logic [COLOR_W-1:0] exp_b[$];
    logic [MOTION_W-1:0] motion;
    int errors;

    function new();
      motion = MAX_MOTION_RST;
      errors = 0;
    endfunction

    // one channel of wheel entry k
    function automatic longint unsigned hue(int k, int ch);
      int r;
      int g;
      int b;
      int j;
      if (k < 15) begin
        r = 255; g = 255 * k / 15; b = 0;
      end else if (k < 21) begin
        j = k - 15; r = 255 - 255 * j / 6; g = 255; b = 0;
      end else if (k < 25) begin
        j = k - 21; r = 0; g = 255; b = 255 * j / 4;
      end else if (k < 36) begin
        j = k - 25; r = 0; g = 255 - 255 * j / 11; b = 255;
      end else if (k < 49) begin
        j = k - 36; r = 255 * j / 13; g = 0; b = 255;
      end else begin
        j = k - 49; r = 255; g = 0; b = 255 - 255 * j / 6;
      end
      return (ch == 0) ? r : ((ch == 1) ? g : b);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n = n - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    // cordic vectoring angle, q16 radians in [0, 2pi)
    function automatic longint flow_angle(longint x, longint y);
      longint base;
      longint z;
      longint xs;
      longint ys;
      longint th;
      base = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x; y = -y; base = PI_Q16;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_Q16[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_Q16[i];
        end
      end
      th = base + z;
      if (th < 0) th = th + TWO_PI_Q16;
      if (th >= TWO_PI_Q16) th = th - TWO_PI_Q16;
      return th;
    endfunction

    // accepted input transfer: compute and queue its color
    function void note_input(logic signed [FLOW_W-1:0] fx, logic signed [FLOW_W-1:0] fy,
                             logic fv);
      longint x;
      longint y;
      longint unsigned d;
      longint unsigned sumsq;
      longint unsigned pos;
      longint unsigned f;
      longint unsigned k0;
      longint unsigned k1;
      longint unsigned v;
      longint unsigned rad;
      longint unsigned w;
      longint unsigned o [3];
      bit in_circle;
      if (!fv) begin
        exp_r.push_back('0); exp_g.push_back('0); exp_b.push_back('0);
        return;
      end
      x = fx;
      y = fy;
      d = ((motion == 0) ? 64'd1 : 64'(motion)) << FRAC;
      sumsq = x * x + y * y;
      in_circle = (sumsq <= d * d);
      pos = (64'(flow_angle(x, y)) * WHEEL_PER_RAD_Q16) >> 16;
      k0 = pos >> 16;
      if (k0 > WHEEL_SIZE - 1) k0 = WHEEL_SIZE - 1;
      f = pos & 64'hFFFF;
      k1 = (k0 + 1 >= WHEEL_SIZE) ? 0 : k0 + 1;
      rad = int_sqrt(sumsq << 32) / d;
      for (int ch = 0; ch < 3; ch++) begin
        v = hue(int'(k0), ch) * (65536 - f) + hue(int'(k1), ch) * f;
        if (in_circle) begin
          w = 64'd255 * 65536 - v;
          o[ch] = ((64'd255 << 32) - w * rad) >> 32;
        end else begin
          o[ch] = (3 * v) >> 18;
        end
      end
      exp_r.push_back(o[0][7:0]);
      exp_g.push_back(o[1][7:0]);
      exp_b.push_back(o[2][7:0]);
    endfunction

    function void check_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                              logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] er;
      logic [COLOR_W-1:0] eg;
      logic [COLOR_W-1:0] eb;
      if (exp_r.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %0d %0d %0d", r, g, b);
        return;
      end
      er = exp_r.pop_front();
      eg = exp_g.pop_front();
      eb = exp_b.pop_front();
      if (r !== er || g !== eg || b !== eb) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   er, eg, eb, r, g, b);
      end
    endfunction

    function int pending();
      return exp_r.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [FLOW_W-1:0] flow_x_i = '0;
  logic signed [FLOW_W-1:0] flow_y_i = '0;
  logic flow_valid_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [MOTION_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [COLOR_W-1:0] red_o;
  logic [COLOR_W-1:0] green_o;
  logic [COLOR_W-1:0] blue_o;

  pixel_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  flow_vector_color_wheel u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .flow_x_i, .flow_y_i, .flow_valid_i,
    .cfg_we_i, .cfg_data_i, .done_o, .red_o, .green_o, .blue_o
  );

  // results are sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni && done_o) sb.check_pixel(red_o, green_o, blue_o);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("FAIL flow_vector_color_wheel");
      $finish;
    end
  end

  // one input transfer; start_i stays high when the next item follows at once
  task automatic send_flow(logic signed [FLOW_W-1:0] x, logic signed [FLOW_W-1:0] y,
                           logic v);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      // end of burst: random gap, sometimes none at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start_i <= 1'b1;
    flow_x_i <= x;
    flow_y_i <= y;
    flow_valid_i <= v;
    do begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
    end while (!ok);
    sb.note_input(x, y, v);
  endtask

  // wait for the pipeline to empty, then let it settle
  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_motion(logic [MOTION_W-1:0] m);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.motion = m;
  endtask

  // mostly vectors near the wheel radius, some full range, a few invalid
  task automatic random_flow(int n);
    int lim;
    logic signed [FLOW_W-1:0] x;
    logic signed [FLOW_W-1:0] y;
    lim = ((sb.motion == 0) ? 1 : int'(sb.motion)) * (1 << FRAC) * 3 / 2;
    if (lim > 32767) lim = 32767;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        x = FLOW_W'(int'($urandom_range(0, 2 * lim)) - lim);
        y = FLOW_W'(int'($urandom_range(0, 2 * lim)) - lim);
      end else begin
        x = FLOW_W'($urandom);
        y = FLOW_W'($urandom);
      end
      send_flow(x, y, $urandom_range(0, 9) != 0);
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  initial begin
    logic signed [FLOW_W-1:0] edge_d;
    logic [MOTION_W-1:0] settings [6];
    settings = '{8'd1, 8'd255, 8'd0, 8'd37, 8'd10, 8'd0};
    settings[5] = MOTION_W'($urandom_range(1, 255));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at the reset motion limit
    edge_d = FLOW_W'(10 << FRAC);
    send_flow(16'sd100, 16'sd100, 1'b0);     // invalid gives black
    send_flow(16'sd0, 16'sd0, 1'b1);         // zero vector gives white
    send_flow(16'sd0, 16'sd0, 1'b0);
    send_flow(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_flow(-16'sd32768, -16'sd32768, 1'b1);
    send_flow(-16'sd32768, 16'sd0, 1'b1);
    send_flow(16'sh7FFF, 16'sd0, 1'b1);
    send_flow(16'sd0, 16'sh7FFF, 1'b1);
    send_flow(16'sd0, -16'sd32768, 1'b1);
    send_flow(-16'sd1, 16'sd0, 1'b1);        // negative x, half-turn
    send_flow(16'sd1000, -16'sd1, 1'b1);     // angle just under a full turn
    send_flow(edge_d, 16'sd0, 1'b1);         // exactly on the unit circle
    send_flow(edge_d + 16'sd1, 16'sd0, 1'b1);
    send_flow(16'sd1, 16'sd1, 1'b1);
    send_flow(-16'sd1, -16'sd1, 1'b1);
    send_flow(16'sd1, 16'sd0, 1'b1);
    send_flow(16'sh5555, -16'sh2AAB, 1'b1);
    send_flow(-16'sh5556, 16'sh2AAA, 1'b1);
    random_flow(60);

    // pause until every pixel is back, then walk the motion settings
    for (int p = 0; p < 6; p++) begin
      drain();
      write_motion(settings[p]);
      if (p == 2) begin
        // motion zero behaves as one; on-circle edge at that setting
        send_flow(16'sd256, 16'sd0, 1'b1);
        send_flow(16'sd257, 16'sd0, 1'b1);
      end
      random_flow(65);
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS flow_vector_color_wheel");
    end else begin
      $display("FAIL flow_vector_color_wheel");
    end
    $finish;
  end

endmodule
